FILE: rtl/core/sfd_pkg.sv
// Shared types and constants of the status frame decoder.
package sfd_pkg;

    localparam int unsigned BYTE_W           = 8;
    localparam int unsigned WORD_W           = 16;
    localparam int unsigned MAX_SENSOR_PORTS = 4;
    localparam int unsigned SENSOR_PORTS_DEF = 4;
    localparam int unsigned BATT_W           = 14;
    localparam int unsigned RAW_W            = 10;
    localparam int unsigned SCALE_W          = 12;
    localparam int unsigned PROD_W           = RAW_W + SCALE_W;
    localparam int unsigned MV_SHIFT         = 8;

    localparam logic [BYTE_W-1:0]  CHECK_GOOD     = 8'hFF;
    localparam logic [BYTE_W-1:0]  FAIL_MAX       = 8'hFF;
    localparam logic [BYTE_W-1:0]  FAIL_LIMIT_RST = 8'd3;

    localparam logic [WORD_W-1:0]  THR_OK     = 16'd1023;
    localparam logic [WORD_W-1:0]  THR_CANCEL = 16'd720;
    localparam logic [WORD_W-1:0]  THR_RIGHT  = 16'd270;
    localparam logic [WORD_W-1:0]  THR_LEFT   = 16'd60;
    localparam logic [SCALE_W-1:0] BATT_SCALE = 12'd3545;

    typedef enum logic [2:0] {
        BTN_NONE   = 3'd0,
        BTN_LEFT   = 3'd1,
        BTN_RIGHT  = 3'd2,
        BTN_CANCEL = 3'd3,
        BTN_OK     = 3'd4
    } t_button;

    typedef struct packed {
        t_button           button;
        logic              supply_aa;
        logic [BATT_W-1:0] battery_mv;
        logic [1:0]        version_major;
        logic [2:0]        version_minor;
    } t_status;

endpackage

FILE: rtl/core/sfd_decode.sv
// Field decode of a stored status frame: sensor words, button class and status word.
module sfd_decode #(
    parameter int unsigned SENSOR_PORTS = sfd_pkg::SENSOR_PORTS_DEF
) (
    input  logic [sfd_pkg::BYTE_W-1:0] i_store [2*SENSOR_PORTS+4],
    output logic [sfd_pkg::WORD_W-1:0] o_sensor [SENSOR_PORTS],
    output sfd_pkg::t_status           o_status
);
    import sfd_pkg::*;

    localparam int unsigned BTN_AT  = 2 * SENSOR_PORTS;
    localparam int unsigned STAT_AT = 2 * SENSOR_PORTS + 2;

    logic [WORD_W-1:0]  btn_word;
    logic [WORD_W-1:0]  stat_word;
    logic [PROD_W-1:0]  batt_prod;

    for (genvar g = 0; g < SENSOR_PORTS; g++) begin : g_sensor
        assign o_sensor[g] = {i_store[2*g+1], i_store[2*g]};
    end

    assign btn_word  = {i_store[BTN_AT+1], i_store[BTN_AT]};
    assign stat_word = {i_store[STAT_AT+1], i_store[STAT_AT]};
    assign batt_prod = PROD_W'(stat_word[RAW_W-1:0]) * PROD_W'(BATT_SCALE);

    always_comb begin
        priority if (btn_word > THR_OK) begin
            o_status.button = BTN_OK;
        end else if (btn_word > THR_CANCEL) begin
            o_status.button = BTN_CANCEL;
        end else if (btn_word > THR_RIGHT) begin
            o_status.button = BTN_RIGHT;
        end else if (btn_word > THR_LEFT) begin
            o_status.button = BTN_LEFT;
        end else begin
            o_status.button = BTN_NONE;
        end
        o_status.supply_aa     = stat_word[15];
        o_status.version_major = stat_word[14:13];
        o_status.version_minor = stat_word[12:10];
        o_status.battery_mv    = batt_prod[MV_SHIFT +: BATT_W];
    end

endmodule

FILE: rtl/core/status_frame_decoder.sv
// Top level of the status frame decoder.
//
// The decoder takes a status frame of 2*SENSOR_PORTS+5 bytes (13 by default), one byte
// per item, with i_frame_start marking the first byte. A byte without i_frame_start while
// no frame is open is dropped, and a new start abandons any partial frame. The bytes are
// summed modulo 256 as they arrive and all but the checksum byte are kept in a small
// register file. When the last byte is accepted, the stored frame is decoded by short
// logic (one 10 x 12 bit multiply for the battery scale) straight into the held output
// registers, and one result item appears on the next cycle. A good frame (sum 0xFF)
// reloads the held readings and clears the failure count; a bad frame leaves them alone
// and counts up, saturating at 255, and reaching fail_limit flags link_lost and clears
// the count. The held output registers double as the result buffer, so o_stall rises
// only while a result is still waiting and the open frame stands at its checksum byte;
// otherwise the input takes one byte every cycle regardless of the output side.
// fail_limit is written through the configuration port, which is always ready.
module status_frame_decoder #(
    parameter int unsigned SENSOR_PORTS = sfd_pkg::SENSOR_PORTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [sfd_pkg::BYTE_W-1:0]  i_cfg_data,
    // input items
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [sfd_pkg::BYTE_W-1:0]  i_rx_byte,
    input  logic                        i_frame_start,
    // result items
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [sfd_pkg::WORD_W-1:0]  o_sensor_a,
    output logic [sfd_pkg::WORD_W-1:0]  o_sensor_b,
    output logic [sfd_pkg::WORD_W-1:0]  o_sensor_c,
    output logic [sfd_pkg::WORD_W-1:0]  o_sensor_d,
    output logic [2:0]                  o_button,
    output logic                        o_supply_aa,
    output logic [sfd_pkg::BATT_W-1:0]  o_battery_mv,
    output logic [1:0]                  o_version_major,
    output logic [2:0]                  o_version_minor,
    output logic                        o_frame_good,
    output logic                        o_link_lost
);
    import sfd_pkg::*;

    localparam int unsigned FRAME_LEN = 2 * SENSOR_PORTS + 5;
    localparam int unsigned STORE_LEN = FRAME_LEN - 1;
    localparam int unsigned POS_W     = $clog2(FRAME_LEN);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

    // Frame assembly state.
    logic [POS_W-1:0]  r_pos,   n_pos;
    logic [BYTE_W-1:0] r_sum,   n_sum;
    logic [BYTE_W-1:0] r_store [STORE_LEN];

    // Link supervision.
    logic [BYTE_W-1:0] r_fail_limit;
    logic [BYTE_W-1:0] r_fail_cnt, n_fail_cnt;

    // Held values, which are also the result payload.
    logic [WORD_W-1:0] r_sensor [MAX_SENSOR_PORTS];
    t_status           r_status;
    logic              r_good, r_lost;
    logic              r_out_valid, n_out_valid;

    // Decode of the stored frame.
    logic [WORD_W-1:0] dec_sensor [SENSOR_PORTS];
    t_status           dec_status;

    logic              in_take;
    logic              in_active;
    logic [POS_W-1:0]  pos_eff;
    logic [BYTE_W-1:0] sum_new;
    logic              is_last;
    logic              frame_ok;
    logic [BYTE_W-1:0] fail_inc;
    logic              fail_hit;

    sfd_decode #(
        .SENSOR_PORTS (SENSOR_PORTS)
    ) u_decode (
        .i_store  (r_store),
        .o_sensor (dec_sensor),
        .o_status (dec_status)
    );

    // A byte can only produce a result when it is the last of an open frame, so the
    // input is held back only in that case while the previous result is unread.
    assign o_stall     = r_out_valid && i_stall && (r_pos == LAST_POS);
    assign in_take     = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        in_active = i_frame_start || (r_pos != '0);
        pos_eff   = i_frame_start ? '0 : r_pos;
        sum_new   = (i_frame_start ? '0 : r_sum) + i_rx_byte;
        is_last   = in_take && in_active && (pos_eff == LAST_POS);
        frame_ok  = (sum_new == CHECK_GOOD);

        fail_inc  = (r_fail_cnt == FAIL_MAX) ? r_fail_cnt : r_fail_cnt + BYTE_W'(1);
        fail_hit  = (fail_inc >= r_fail_limit);

        n_pos      = r_pos;
        n_sum      = r_sum;
        n_fail_cnt = r_fail_cnt;
        if (in_take && in_active) begin
            if (is_last) begin
                n_pos = '0;
                n_sum = '0;
                if (frame_ok) begin
                    n_fail_cnt = '0;
                end else begin
                    n_fail_cnt = fail_hit ? '0 : fail_inc;
                end
            end else begin
                n_pos = pos_eff + POS_W'(1);
                n_sum = sum_new;
            end
        end

        n_out_valid = is_last || (r_out_valid && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_sum        <= '0;
            r_fail_cnt   <= '0;
            r_fail_limit <= FAIL_LIMIT_RST;
            r_out_valid  <= 1'b0;
            r_good       <= 1'b0;
            r_lost       <= 1'b0;
            r_status     <= '{button: BTN_NONE, default: '0};
        end else begin
            r_pos       <= n_pos;
            r_sum       <= n_sum;
            r_fail_cnt  <= n_fail_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_fail_limit <= i_cfg_data;
            end
            if (is_last) begin
                r_good <= frame_ok;
                r_lost <= !frame_ok && fail_hit;
                if (frame_ok) begin
                    r_status <= dec_status;
                end
            end
        end
    end

    // Frame bytes other than the checksum; no reset is needed as every entry is
    // written before a frame can complete.
    for (genvar g = 0; g < STORE_LEN; g++) begin : g_store
        always_ff @(posedge i_clk) begin
            if (in_take && in_active && !is_last && (pos_eff == POS_W'(g))) begin
                r_store[g] <= i_rx_byte;
            end
        end
    end

    // Held sensor readings; ports beyond SENSOR_PORTS stay at zero.
    for (genvar g = 0; g < MAX_SENSOR_PORTS; g++) begin : g_held
        if (g < SENSOR_PORTS) begin : g_used
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sensor[g] <= '0;
                end else if (is_last && frame_ok) begin
                    r_sensor[g] <= dec_sensor[g];
                end
            end
        end else begin : g_unused
            always_ff @(posedge i_clk) begin
                r_sensor[g] <= '0;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_sensor_a      = r_sensor[0];
    assign o_sensor_b      = r_sensor[1];
    assign o_sensor_c      = r_sensor[2];
    assign o_sensor_d      = r_sensor[3];
    assign o_button        = r_status.button;
    assign o_supply_aa     = r_status.supply_aa;
    assign o_battery_mv    = r_status.battery_mv;
    assign o_version_major = r_status.version_major;
    assign o_version_minor = r_status.version_minor;
    assign o_frame_good    = r_good;
    assign o_link_lost     = r_lost;

    // The byte counter never runs past the checksum position.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= LAST_POS)
        else $error("byte position beyond frame end");

    // Closing a frame always leaves a result waiting on the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && !i_frame_start && r_pos == LAST_POS) |=> (o_valid && r_pos == '0))
        else $error("completed frame gave no result");

    // A good frame never reports a lost link.
    a_good_not_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_frame_good && o_link_lost))
        else $error("good frame flagged link lost");

    // After a good frame or a link restart the failure count is zero.
    a_count_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_frame_good || o_link_lost)) |-> (r_fail_cnt == '0))
        else $error("failure count not cleared");

endmodule

FILE: verif/tb_status_frame_decoder.sv
// Self-checking testbench of the status frame decoder: random status frames against a readout predictor.
`timescale 1ns / 1ps

module tb_status_frame_decoder;
    import sfd_pkg::*;

    // The block is built with its default number of sensor ports, so a frame is 13 bytes:
    // twelve body bytes (four sensor words, the button word, the status word) and a checksum.
    localparam int unsigned SENSOR_PORTS = SENSOR_PORTS_DEF;
    localparam int unsigned FRAME_BYTES  = 2 * SENSOR_PORTS + 5;
    localparam int unsigned BODY_BYTES   = FRAME_BYTES - 1;

    // Button word thresholds and the battery scale, as the coprocessor documents them.
    localparam logic [15:0] ABOVE_OK      = 16'd1023;
    localparam logic [15:0] ABOVE_CANCEL  = 16'd720;
    localparam logic [15:0] ABOVE_RIGHT   = 16'd270;
    localparam logic [15:0] ABOVE_LEFT    = 16'd60;
    localparam logic [21:0] MV_PER_COUNT  = 22'd3545;

    // A result comes out on the cycle after the checksum byte, so these pauses are ample
    // for anything still in flight before a register write or at the end of the run.
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned END_CYCLES    = 16;
    localparam int unsigned STALL_LIMIT   = 2000;

    typedef struct packed {
        logic [7:0] b;
        logic       start;
    } t_rx_item;

    typedef struct packed {
        logic [15:0] sensor_a;
        logic [15:0] sensor_b;
        logic [15:0] sensor_c;
        logic [15:0] sensor_d;
        t_button     button;
        logic        supply_aa;
        logic [13:0] battery_mv;
        logic [1:0]  version_major;
        logic [2:0]  version_minor;
        logic        frame_good;
        logic        link_lost;
    } t_frame_readout;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [7:0]  i_cfg_data = 8'd0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_rx_byte = 8'd0;
    logic        i_frame_start = 1'b0;
    logic        i_stall = 1'b0;

    logic        o_cfg_ready;
    logic        o_stall;
    logic        o_valid;
    logic [15:0] o_sensor_a;
    logic [15:0] o_sensor_b;
    logic [15:0] o_sensor_c;
    logic [15:0] o_sensor_d;
    logic [2:0]  o_button;
    logic        o_supply_aa;
    logic [13:0] o_battery_mv;
    logic [1:0]  o_version_major;
    logic [2:0]  o_version_minor;
    logic        o_frame_good;
    logic        o_link_lost;

    status_frame_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_rx_byte       (i_rx_byte),
        .i_frame_start   (i_frame_start),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_sensor_a      (o_sensor_a),
        .o_sensor_b      (o_sensor_b),
        .o_sensor_c      (o_sensor_c),
        .o_sensor_d      (o_sensor_d),
        .o_button        (o_button),
        .o_supply_aa     (o_supply_aa),
        .o_battery_mv    (o_battery_mv),
        .o_version_major (o_version_major),
        .o_version_minor (o_version_minor),
        .o_frame_good    (o_frame_good),
        .o_link_lost     (o_link_lost)
    );

    // Bytes waiting to be offered, and the readouts that accepted frames are due to produce.
    t_rx_item       byte_stream[$];
    t_frame_readout expected_frames[$];

    // Our own copy of the decoder state. The held readouts start at zero with no button.
    logic [3:0]     frame_pos = 4'd0;
    logic [7:0]     byte_sum = 8'd0;
    logic [7:0]     frame_bytes [BODY_BYTES];
    logic [7:0]     fail_run = 8'd0;
    logic [7:0]     fail_limit = FAIL_LIMIT_RST;
    t_frame_readout held_status = '0;

    int unsigned    mismatches = 0;
    int unsigned    quiet_cycles = 0;
    bit             idling_on = 1'b1;
    bit             send_calm = 1'b0;
    bit             take_calm = 1'b0;
    int unsigned    send_gap = 0;
    int unsigned    take_gap = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Predictor: folds one accepted byte into the frame state. When the byte closes a frame,
    // the readout the block should show for it is queued.
    function automatic void absorb_byte(input logic [7:0] b, input logic start);
        t_frame_readout readout;
        logic [15:0]    w;
        logic [21:0]    product;
        logic           good;
        logic           lost;

        lost = 1'b0;
        // A start always opens a new frame, dropping whatever was half received. Without a
        // start, a byte only counts while a frame is open.
        if (start) begin
            frame_pos = 4'd0;
            byte_sum  = 8'd0;
        end else if (frame_pos == 4'd0) begin
            return;
        end
        byte_sum = byte_sum + b;
        if (frame_pos < BODY_BYTES) begin
            frame_bytes[frame_pos] = b;
            frame_pos = frame_pos + 4'd1;
            return;
        end

        // This is the checksum byte: the whole frame must sum to all ones.
        frame_pos = 4'd0;
        good      = (byte_sum == 8'hFF);
        byte_sum  = 8'd0;
        if (good) begin
            fail_run = 8'd0;
            held_status.sensor_a = {frame_bytes[1], frame_bytes[0]};
            held_status.sensor_b = {frame_bytes[3], frame_bytes[2]};
            held_status.sensor_c = {frame_bytes[5], frame_bytes[4]};
            held_status.sensor_d = {frame_bytes[7], frame_bytes[6]};

            w = {frame_bytes[9], frame_bytes[8]};
            if (w > ABOVE_OK) begin
                held_status.button = BTN_OK;
            end else if (w > ABOVE_CANCEL) begin
                held_status.button = BTN_CANCEL;
            end else if (w > ABOVE_RIGHT) begin
                held_status.button = BTN_RIGHT;
            end else if (w > ABOVE_LEFT) begin
                held_status.button = BTN_LEFT;
            end else begin
                held_status.button = BTN_NONE;
            end

            // Status word: supply type on top, then the version, then the raw battery count.
            w = {frame_bytes[11], frame_bytes[10]};
            held_status.supply_aa     = w[15];
            held_status.version_major = w[14:13];
            held_status.version_minor = w[12:10];
            product = 22'(w[9:0]) * MV_PER_COUNT;
            held_status.battery_mv = product[21:8];
        end else begin
            // The run of bad frames saturates rather than wrapping; at the limit the link is
            // declared lost and counting starts afresh. A zero limit trips on every bad frame.
            if (fail_run != 8'hFF) begin
                fail_run = fail_run + 8'd1;
            end
            if (fail_run >= fail_limit) begin
                lost     = 1'b1;
                fail_run = 8'd0;
            end
        end

        readout            = held_status;
        readout.frame_good = good;
        readout.link_lost  = lost;
        expected_frames.push_back(readout);
    endfunction

    function automatic void compare_field(input string field, input logic [15:0] want,
                                          input logic [15:0] seen);
        if (seen !== want) begin
            mismatches++;
            $error("%s: expected 0x%0h, got 0x%0h", field, want, seen);
        end
    endfunction

    // Sender. A stalled byte is held as it is; otherwise the next byte is offered, now and
    // then after a short gap. Gaps come in bursts of random length, and calm stretches
    // with no gaps at all come and go at random.
    always @(posedge i_clk) begin
        t_rx_item item;
        logic     took;

        if (i_rst_n) begin
            took = i_valid && !o_stall;
            if (took) begin
                absorb_byte(i_rx_byte, i_frame_start);
            end
            if ($urandom_range(0, 63) == 0) begin
                send_calm = !send_calm;
            end

            if (i_valid && !took) begin
                // hold the stalled item
            end else if (send_gap != 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (byte_stream.size() != 0 && idling_on && !send_calm &&
                         $urandom_range(0, 4) == 0) begin
                send_gap = $urandom_range(0, 3);
                i_valid <= 1'b0;
            end else if (byte_stream.size() != 0) begin
                item = byte_stream.pop_front();
                i_valid       <= 1'b1;
                i_rx_byte     <= item.b;
                i_frame_start <= item.start;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver. Every accepted result item is checked against the oldest expected readout;
    // the stall is raised in bursts of the same kind as the sender's gaps.
    always @(posedge i_clk) begin
        t_frame_readout want;

        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_frames.size() == 0) begin
                    mismatches++;
                    $error("result item with no frame awaiting its readout");
                end else begin
                    want = expected_frames.pop_front();
                    compare_field("sensor_a", want.sensor_a, o_sensor_a);
                    compare_field("sensor_b", want.sensor_b, o_sensor_b);
                    compare_field("sensor_c", want.sensor_c, o_sensor_c);
                    compare_field("sensor_d", want.sensor_d, o_sensor_d);
                    compare_field("button", 16'(want.button), 16'(o_button));
                    compare_field("supply_aa", 16'(want.supply_aa), 16'(o_supply_aa));
                    compare_field("battery_mv", 16'(want.battery_mv), 16'(o_battery_mv));
                    compare_field("version_major", 16'(want.version_major),
                                  16'(o_version_major));
                    compare_field("version_minor", 16'(want.version_minor),
                                  16'(o_version_minor));
                    compare_field("frame_good", 16'(want.frame_good), 16'(o_frame_good));
                    compare_field("link_lost", 16'(want.link_lost), 16'(o_link_lost));
                end
            end

            if ($urandom_range(0, 63) == 0) begin
                take_calm = !take_calm;
            end
            if (take_gap != 0) begin
                take_gap--;
                i_stall <= 1'b1;
            end else if (idling_on && !take_calm && $urandom_range(0, 4) == 0) begin
                take_gap = $urandom_range(0, 3);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog: a long spell with no handshake on any channel means the block has hung.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $error("no handshake for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Queues one frame: the twelve body bytes little endian, then a checksum that either
    // makes the frame sum to all ones or misses by a random nonzero amount.
    task automatic queue_frame(input logic [95:0] body, input bit ok);
        t_rx_item   item;
        logic [7:0] sum;
        int         i;

        sum = 8'd0;
        for (i = 0; i < BODY_BYTES; i++) begin
            item.b     = body[8*i +: 8];
            item.start = (i == 0);
            sum        = sum + item.b;
            byte_stream.push_back(item);
        end
        item.start = 1'b0;
        item.b     = 8'hFF - sum;
        if (!ok) begin
            item.b = item.b + 8'($urandom_range(1, 255));
        end
        byte_stream.push_back(item);
    endtask

    // Random frame body, weighted towards all-zero and all-one sensor words, button words
    // on either side of each threshold, and the ends of the battery count.
    function automatic logic [95:0] random_body();
        logic [95:0] body;
        logic [15:0] w;
        int          i;

        for (i = 0; i < 4; i++) begin
            case ($urandom_range(0, 3))
                0:       w = 16'h0000;
                1:       w = 16'hFFFF;
                default: w = 16'($urandom);
            endcase
            body[16*i +: 16] = w;
        end

        case ($urandom_range(0, 3))
            0, 1: begin
                case ($urandom_range(0, 9))
                    0:       w = 16'd0;
                    1:       w = ABOVE_LEFT;
                    2:       w = ABOVE_LEFT + 16'd1;
                    3:       w = ABOVE_RIGHT;
                    4:       w = ABOVE_RIGHT + 16'd1;
                    5:       w = ABOVE_CANCEL;
                    6:       w = ABOVE_CANCEL + 16'd1;
                    7:       w = ABOVE_OK;
                    8:       w = ABOVE_OK + 16'd1;
                    default: w = 16'hFFFF;
                endcase
            end
            2:       w = 16'($urandom_range(0, 1100));
            default: w = 16'($urandom);
        endcase
        body[79:64] = w;

        w = 16'($urandom);
        case ($urandom_range(0, 3))
            0:       w[9:0] = 10'h3FF;
            1:       w[9:0] = 10'h000;
            default: ;
        endcase
        body[95:80] = w;
        return body;
    endfunction

    // Mostly well-formed frames, good more often than bad, with runs of bad frames long enough
    // to reach the failure limit. The rest is noise: stray bytes with no frame open and
    // frames cut short by a fresh start. Stray bytes are not counted towards the total.
    task automatic queue_traffic(input int unsigned n_items, input int unsigned run_max);
        t_rx_item    item;
        int unsigned queued;
        int unsigned k;
        int unsigned j;

        queued = 0;
        while (queued < n_items) begin
            case ($urandom_range(0, 19))
                0: begin
                    for (k = $urandom_range(1, 3); k != 0; k--) begin
                        item.b     = 8'($urandom);
                        item.start = 1'b0;
                        byte_stream.push_back(item);
                    end
                end
                1: begin
                    j = $urandom_range(0, BODY_BYTES - 1);
                    item.b     = 8'($urandom);
                    item.start = 1'b1;
                    byte_stream.push_back(item);
                    for (k = 0; k < j; k++) begin
                        item.b     = 8'($urandom);
                        item.start = 1'b0;
                        byte_stream.push_back(item);
                    end
                    queued += j + 1;
                end
                2: begin
                    j = $urandom_range(1, run_max);
                    for (k = 0; k < j; k++) begin
                        queue_frame(random_body(), 1'b0);
                    end
                    queued += j * FRAME_BYTES;
                end
                default: begin
                    queue_frame(random_body(), $urandom_range(0, 3) != 0);
                    queued += FRAME_BYTES;
                end
            endcase
        end
    endtask

    // Waits until every queued byte has gone in and every expected readout has come out.
    task automatic drain();
        while (byte_stream.size() != 0 || i_valid || expected_frames.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // The limit is only changed with the decoder idle, after a short settling pause.
    task automatic write_fail_limit(input logic [7:0] value);
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        fail_limit = value;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        t_rx_item item;
        int       k;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening, with the limit at its reset value. A byte with no frame open must
        // be ignored. A frame cut short by a new start must vanish without a result, and the
        // frame that replaces it carries the extremes: zero and full sensor words, the ok
        // button, AA supply, the highest version and the largest battery count.
        item.b     = 8'hA5;
        item.start = 1'b0;
        byte_stream.push_back(item);
        for (k = 0; k < 3; k++) begin
            item.b     = 8'($urandom);
            item.start = (k == 0);
            byte_stream.push_back(item);
        end
        queue_frame({16'hFFFF, ABOVE_OK + 16'd1, 16'h7FFE, 16'h8001, 16'hFFFF, 16'h0000}, 1'b1);
        queue_traffic(300, 5);

        // One bad frame is enough to lose the link.
        write_fail_limit(8'd1);
        queue_traffic(200, 3);

        // A large limit: only an unbroken run of 40 bad frames trips it, and the frame after
        // that starts a new run.
        write_fail_limit(8'd40);
        for (k = 0; k < 41; k++) begin
            queue_frame(random_body(), 1'b0);
        end
        queue_frame(random_body(), 1'b1);
        queue_traffic(100, 10);

        // A zero limit behaves like a limit of one.
        write_fail_limit(8'd0);
        queue_traffic(200, 3);

        write_fail_limit(8'($urandom_range(2, 40)));
        queue_traffic(300, 45);

        // Closing part at full rate on both sides.
        write_fail_limit(8'd2);
        idling_on = 1'b0;
        queue_traffic(250, 4);

        drain();
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/sfd_pkg.sv
rtl/core/sfd_decode.sv
rtl/core/status_frame_decoder.sv
verif/tb_status_frame_decoder.sv
